// ===== design/tfim_pkg.sv =====
`default_nettype none
package tfim_pkg;

  localparam int unsigned IDX_W      = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned SIZE_REGS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3 = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0]  source_index;
    logic [ELEM_W-1:0] element_in;
  } tfim_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  dest_index;
    logic [ELEM_W-1:0] element_out;
    logic              index_out_of_range;
  } tfim_out_t;

  // item context handed from cell to cell
  typedef struct packed {
    logic [IDX_W-1:0]  quo;
    logic [SIZE_W-1:0] rmd;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  stride;
    logic              big;
    logic              zero;
    logic [ELEM_W-1:0] elem;
  } tfim_ctx_t;

endpackage
`default_nettype wire

// ===== design/tfim_div_cell.sv =====
`default_nettype none
module tfim_div_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire tfim_pkg::tfim_ctx_t         ctx_i,
  input  wire logic [tfim_pkg::SIZE_W-1:0] size_i,
  output logic                             vld_o,
  output tfim_pkg::tfim_ctx_t              ctx_o
);
  import tfim_pkg::*;

  logic                vld_q;
  tfim_ctx_t           ctx_q, ctx_d;
  logic [SIZE_W:0]     sh;
  logic [SIZE_W:0]     diff;

  // one restoring division step
  always_comb begin
    sh    = {ctx_i.rmd, ctx_i.quo[IDX_W-1]};
    diff  = sh - {1'b0, size_i};
    ctx_d = ctx_i;
    if (sh >= {1'b0, size_i}) begin
      ctx_d.rmd = diff[SIZE_W-1:0];
      ctx_d.quo = {ctx_i.quo[IDX_W-2:0], 1'b1};
    end else begin
      ctx_d.rmd = sh[SIZE_W-1:0];
      ctx_d.quo = {ctx_i.quo[IDX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= ctx_d;
    end
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;

endmodule
`default_nettype wire

// ===== design/tfim_merge_cell.sv =====
`default_nettype none
module tfim_merge_cell #(
  parameter int unsigned IW = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire tfim_pkg::tfim_ctx_t         ctx_i,
  input  wire logic [tfim_pkg::SIZE_W-1:0] size_i,
  input  wire logic                        flip_i,
  output logic                             vld_o,
  output tfim_pkg::tfim_ctx_t              ctx_o
);
  import tfim_pkg::*;

  localparam int unsigned PW = IDX_W + SIZE_W;
  localparam logic [IDX_W-1:0] IMASK = {IDX_W{1'b1}} >> (IDX_W - IW);

  logic              vld1_q, vld2_q;
  tfim_ctx_t         ctx1_q, ctx2_q, ctx2_d;
  logic [PW-1:0]     pc_q, ps_q;
  logic [SIZE_W-1:0] size1_q;
  logic [SIZE_W-1:0] coord;
  logic              zero_n;
  logic [IDX_W-1:0]  dsum;

  // mirror the coordinate if flipped
  assign coord = flip_i ? (size_i - ctx_i.rmd - 16'd1) : ctx_i.rmd;

  always_comb begin
    ctx2_d        = ctx1_q;
    zero_n        = ctx1_q.zero || (size1_q == '0);
    dsum          = ctx1_q.dest + pc_q[IDX_W-1:0];
    ctx2_d.rmd    = '0;
    ctx2_d.dest   = dsum & IMASK;
    ctx2_d.stride = ps_q[IDX_W-1:0] & IMASK;
    ctx2_d.zero   = zero_n;
    ctx2_d.big    = !zero_n && (ctx1_q.big || ((ps_q >> IW) != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q  <= ctx_i;
      size1_q <= size_i;
      pc_q    <= PW'(coord) * PW'(ctx_i.stride);
      ps_q    <= PW'(ctx_i.stride) * PW'(size_i);
      ctx2_q  <= ctx2_d;
    end
  end

  assign vld_o = vld2_q;
  assign ctx_o = ctx2_q;

endmodule
`default_nettype wire

// ===== design/tensor_flip_index_mapper.sv =====
`default_nettype none
// Tensor flip index mapper: each transaction carries a linear source index and a byte;
// the index is split into mixed-radix coordinates (dimension 0 most significant),
// flagged coordinates are mirrored and the destination index is rebuilt. One
// transaction is taken per cycle while the output is not stalled. Each dimension
// passes a chain of 32 one-bit restoring divider cells and a two-stage merge cell that
// mirrors the coordinate and accumulates it with its stride. The whole chain advances
// together and halts while a result is held at the output. Configure only when idle.
module tensor_flip_index_mapper #(
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire tfim_pkg::tfim_in_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output tfim_pkg::tfim_out_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tfim_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tfim_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tfim_pkg::*;

  localparam int unsigned IW    = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
  localparam logic [IDX_W-1:0] IMASK = {IDX_W{1'b1}} >> (IDX_W - IW);
  localparam int unsigned SEG   = IDX_W + 1;
  localparam int unsigned NODES = MAX_DIMS * SEG + 1;

  logic [COUNT_W-1:0] count_q;
  logic [MASK_W-1:0]  mask_q;
  logic [SIZE_W-1:0]  size_q [SIZE_REGS];
  logic [COUNT_W:0]   cnt_eff;

  logic               en;
  logic               vld0_q;
  tfim_ctx_t          ctx0_q;
  logic               out_vld_q;
  tfim_out_t          out_q;
  tfim_ctx_t          fin;
  logic               oor;

  logic               vld_n [NODES];
  tfim_ctx_t          ctx_n [NODES];
  logic [SIZE_W-1:0]  eff_size [MAX_DIMS];
  logic               eff_flip [MAX_DIMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      mask_q  <= '0;
      for (int i = 0; i < SIZE_REGS; i++) begin
        size_q[i] <= SIZE_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIM_COUNT: count_q   <= cfg_data_i[COUNT_W-1:0];
        REG_FLIP_MASK: mask_q    <= cfg_data_i[MASK_W-1:0];
        REG_SIZE_DIM0: size_q[0] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_DIM1: size_q[1] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_DIM2: size_q[2] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_DIM3: size_q[3] <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimension count to 1..MAX_DIMS
  always_comb begin
    if (count_q == '0) begin
      cnt_eff = (COUNT_W+1)'(1);
    end else if ({1'b0, count_q} > (COUNT_W+1)'(MAX_DIMS)) begin
      cnt_eff = (COUNT_W+1)'(MAX_DIMS);
    end else begin
      cnt_eff = {1'b0, count_q};
    end
  end

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld0_q    <= in_valid_i;
      out_vld_q <= vld_n[NODES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx0_q.quo    <= in_data_i.source_index & IMASK;
      ctx0_q.rmd    <= '0;
      ctx0_q.idx    <= in_data_i.source_index & IMASK;
      ctx0_q.dest   <= '0;
      ctx0_q.stride <= IDX_W'(1);
      ctx0_q.big    <= 1'b0;
      ctx0_q.zero   <= 1'b0;
      ctx0_q.elem   <= in_data_i.element_in;
      out_q.dest_index         <= oor ? '0 : fin.dest;
      out_q.element_out        <= fin.elem;
      out_q.index_out_of_range <= oor;
    end
  end

  assign vld_n[0] = vld0_q;
  assign ctx_n[0] = ctx0_q;

  // least significant dimension first
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_dim
    localparam int unsigned K = MAX_DIMS - 1 - j;
    if (K < SIZE_REGS) begin : g_reg
      assign eff_size[K] = ((COUNT_W+1)'(K) < cnt_eff) ? size_q[K] : SIZE_W'(1);
      assign eff_flip[K] = ((COUNT_W+1)'(K) < cnt_eff) && mask_q[K];
    end else begin : g_one
      assign eff_size[K] = SIZE_W'(1);
      assign eff_flip[K] = 1'b0;
    end
    for (genvar i = 0; i < IDX_W; i++) begin : g_step
      tfim_div_cell u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .vld_i  (vld_n[j*SEG+i]),
        .ctx_i  (ctx_n[j*SEG+i]),
        .size_i (eff_size[K]),
        .vld_o  (vld_n[j*SEG+i+1]),
        .ctx_o  (ctx_n[j*SEG+i+1])
      );
    end
    tfim_merge_cell #(.IW(IW)) u_merge (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_n[j*SEG+IDX_W]),
      .ctx_i  (ctx_n[j*SEG+IDX_W]),
      .size_i (eff_size[K]),
      .flip_i (eff_flip[K]),
      .vld_o  (vld_n[(j+1)*SEG]),
      .ctx_o  (ctx_n[(j+1)*SEG])
    );
  end

  assign fin = ctx_n[NODES-1];
  assign oor = fin.zero || (!fin.big && (fin.idx >= fin.stride));

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
